### hw/rtl/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Shared types, register indexes, S-box tables and round helpers.
// ----------------------------------------------------------------------------
package aescbc_pkg;

   localparam int unsigned KeyWordCount = 22;
   localparam int unsigned KeyAddrWidth = 5;
   localparam int unsigned CsrIdxWidth  = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_KEY_HIGH     = 3'd0,
      CSR_KEY_LOW      = 3'd1,
      CSR_IV_HIGH      = 3'd2,
      CSR_IV_LOW       = 3'd3,
      CSR_DECRYPT_MODE = 3'd4
   } csr_idx_type;

   typedef logic [127:0] block_type;

   // key-schedule write request toward the round-key memory
   typedef struct packed {
      logic                    wr_en;
      logic [KeyAddrWidth-1:0] wr_addr;
      logic [63:0]             wr_data;
   } key_wr_type;

   function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
         8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
         8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
         8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
         8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
         8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
         8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
         8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
         8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
         8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
         8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
         8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
         8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
         8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
         8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
         8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
         8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
         8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
         8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
         8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
         8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
         8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
         8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
         8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
         8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
         8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
         8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
         8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
         8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
         8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
         8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
         8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
         8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
         8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
         8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
         8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
         8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
         8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
         8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
         8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
         8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
         8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
         8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
         8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
         8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
         8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
         8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
         8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
         8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
         8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
         8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
         8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
         8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; default: r=8'h16;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6A; 8'h03: r=8'hD5;
         8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'hA5; 8'h07: r=8'h38;
         8'h08: r=8'hBF; 8'h09: r=8'h40; 8'h0A: r=8'hA3; 8'h0B: r=8'h9E;
         8'h0C: r=8'h81; 8'h0D: r=8'hF3; 8'h0E: r=8'hD7; 8'h0F: r=8'hFB;
         8'h10: r=8'h7C; 8'h11: r=8'hE3; 8'h12: r=8'h39; 8'h13: r=8'h82;
         8'h14: r=8'h9B; 8'h15: r=8'h2F; 8'h16: r=8'hFF; 8'h17: r=8'h87;
         8'h18: r=8'h34; 8'h19: r=8'h8E; 8'h1A: r=8'h43; 8'h1B: r=8'h44;
         8'h1C: r=8'hC4; 8'h1D: r=8'hDE; 8'h1E: r=8'hE9; 8'h1F: r=8'hCB;
         8'h20: r=8'h54; 8'h21: r=8'h7B; 8'h22: r=8'h94; 8'h23: r=8'h32;
         8'h24: r=8'hA6; 8'h25: r=8'hC2; 8'h26: r=8'h23; 8'h27: r=8'h3D;
         8'h28: r=8'hEE; 8'h29: r=8'h4C; 8'h2A: r=8'h95; 8'h2B: r=8'h0B;
         8'h2C: r=8'h42; 8'h2D: r=8'hFA; 8'h2E: r=8'hC3; 8'h2F: r=8'h4E;
         8'h30: r=8'h08; 8'h31: r=8'h2E; 8'h32: r=8'hA1; 8'h33: r=8'h66;
         8'h34: r=8'h28; 8'h35: r=8'hD9; 8'h36: r=8'h24; 8'h37: r=8'hB2;
         8'h38: r=8'h76; 8'h39: r=8'h5B; 8'h3A: r=8'hA2; 8'h3B: r=8'h49;
         8'h3C: r=8'h6D; 8'h3D: r=8'h8B; 8'h3E: r=8'hD1; 8'h3F: r=8'h25;
         8'h40: r=8'h72; 8'h41: r=8'hF8; 8'h42: r=8'hF6; 8'h43: r=8'h64;
         8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
         8'h48: r=8'hD4; 8'h49: r=8'hA4; 8'h4A: r=8'h5C; 8'h4B: r=8'hCC;
         8'h4C: r=8'h5D; 8'h4D: r=8'h65; 8'h4E: r=8'hB6; 8'h4F: r=8'h92;
         8'h50: r=8'h6C; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
         8'h54: r=8'hFD; 8'h55: r=8'hED; 8'h56: r=8'hB9; 8'h57: r=8'hDA;
         8'h58: r=8'h5E; 8'h59: r=8'h15; 8'h5A: r=8'h46; 8'h5B: r=8'h57;
         8'h5C: r=8'hA7; 8'h5D: r=8'h8D; 8'h5E: r=8'h9D; 8'h5F: r=8'h84;
         8'h60: r=8'h90; 8'h61: r=8'hD8; 8'h62: r=8'hAB; 8'h63: r=8'h00;
         8'h64: r=8'h8C; 8'h65: r=8'hBC; 8'h66: r=8'hD3; 8'h67: r=8'h0A;
         8'h68: r=8'hF7; 8'h69: r=8'hE4; 8'h6A: r=8'h58; 8'h6B: r=8'h05;
         8'h6C: r=8'hB8; 8'h6D: r=8'hB3; 8'h6E: r=8'h45; 8'h6F: r=8'h06;
         8'h70: r=8'hD0; 8'h71: r=8'h2C; 8'h72: r=8'h1E; 8'h73: r=8'h8F;
         8'h74: r=8'hCA; 8'h75: r=8'h3F; 8'h76: r=8'h0F; 8'h77: r=8'h02;
         8'h78: r=8'hC1; 8'h79: r=8'hAF; 8'h7A: r=8'hBD; 8'h7B: r=8'h03;
         8'h7C: r=8'h01; 8'h7D: r=8'h13; 8'h7E: r=8'h8A; 8'h7F: r=8'h6B;
         8'h80: r=8'h3A; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
         8'h84: r=8'h4F; 8'h85: r=8'h67; 8'h86: r=8'hDC; 8'h87: r=8'hEA;
         8'h88: r=8'h97; 8'h89: r=8'hF2; 8'h8A: r=8'hCF; 8'h8B: r=8'hCE;
         8'h8C: r=8'hF0; 8'h8D: r=8'hB4; 8'h8E: r=8'hE6; 8'h8F: r=8'h73;
         8'h90: r=8'h96; 8'h91: r=8'hAC; 8'h92: r=8'h74; 8'h93: r=8'h22;
         8'h94: r=8'hE7; 8'h95: r=8'hAD; 8'h96: r=8'h35; 8'h97: r=8'h85;
         8'h98: r=8'hE2; 8'h99: r=8'hF9; 8'h9A: r=8'h37; 8'h9B: r=8'hE8;
         8'h9C: r=8'h1C; 8'h9D: r=8'h75; 8'h9E: r=8'hDF; 8'h9F: r=8'h6E;
         8'hA0: r=8'h47; 8'hA1: r=8'hF1; 8'hA2: r=8'h1A; 8'hA3: r=8'h71;
         8'hA4: r=8'h1D; 8'hA5: r=8'h29; 8'hA6: r=8'hC5; 8'hA7: r=8'h89;
         8'hA8: r=8'h6F; 8'hA9: r=8'hB7; 8'hAA: r=8'h62; 8'hAB: r=8'h0E;
         8'hAC: r=8'hAA; 8'hAD: r=8'h18; 8'hAE: r=8'hBE; 8'hAF: r=8'h1B;
         8'hB0: r=8'hFC; 8'hB1: r=8'h56; 8'hB2: r=8'h3E; 8'hB3: r=8'h4B;
         8'hB4: r=8'hC6; 8'hB5: r=8'hD2; 8'hB6: r=8'h79; 8'hB7: r=8'h20;
         8'hB8: r=8'h9A; 8'hB9: r=8'hDB; 8'hBA: r=8'hC0; 8'hBB: r=8'hFE;
         8'hBC: r=8'h78; 8'hBD: r=8'hCD; 8'hBE: r=8'h5A; 8'hBF: r=8'hF4;
         8'hC0: r=8'h1F; 8'hC1: r=8'hDD; 8'hC2: r=8'hA8; 8'hC3: r=8'h33;
         8'hC4: r=8'h88; 8'hC5: r=8'h07; 8'hC6: r=8'hC7; 8'hC7: r=8'h31;
         8'hC8: r=8'hB1; 8'hC9: r=8'h12; 8'hCA: r=8'h10; 8'hCB: r=8'h59;
         8'hCC: r=8'h27; 8'hCD: r=8'h80; 8'hCE: r=8'hEC; 8'hCF: r=8'h5F;
         8'hD0: r=8'h60; 8'hD1: r=8'h51; 8'hD2: r=8'h7F; 8'hD3: r=8'hA9;
         8'hD4: r=8'h19; 8'hD5: r=8'hB5; 8'hD6: r=8'h4A; 8'hD7: r=8'h0D;
         8'hD8: r=8'h2D; 8'hD9: r=8'hE5; 8'hDA: r=8'h7A; 8'hDB: r=8'h9F;
         8'hDC: r=8'h93; 8'hDD: r=8'hC9; 8'hDE: r=8'h9C; 8'hDF: r=8'hEF;
         8'hE0: r=8'hA0; 8'hE1: r=8'hE0; 8'hE2: r=8'h3B; 8'hE3: r=8'h4D;
         8'hE4: r=8'hAE; 8'hE5: r=8'h2A; 8'hE6: r=8'hF5; 8'hE7: r=8'hB0;
         8'hE8: r=8'hC8; 8'hE9: r=8'hEB; 8'hEA: r=8'hBB; 8'hEB: r=8'h3C;
         8'hEC: r=8'h83; 8'hED: r=8'h53; 8'hEE: r=8'h99; 8'hEF: r=8'h61;
         8'hF0: r=8'h17; 8'hF1: r=8'h2B; 8'hF2: r=8'h04; 8'hF3: r=8'h7E;
         8'hF4: r=8'hBA; 8'hF5: r=8'h77; 8'hF6: r=8'hD6; 8'hF7: r=8'h26;
         8'hF8: r=8'hE1; 8'hF9: r=8'h69; 8'hFA: r=8'h14; 8'hFB: r=8'h63;
         8'hFC: r=8'h55; 8'hFD: r=8'h21; 8'hFE: r=8'h0C; default: r=8'h7D;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // byte i of a block: i = 0 is bits 127:120
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic block_type enc_round(input block_type s, input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      block_type  o;
      // substitute and shift rows
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4+r] = fwd_sbox(get_byte(s, ((c + r) % 4)*4 + r));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
         if (!last) begin
            t[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
      return o;
   endfunction

   function automatic logic [7:0] mul_e(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x4 ^ x2;
   endfunction
   function automatic logic [7:0] mul_b(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x2 ^ a;
   endfunction
   function automatic logic [7:0] mul_d(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x4 ^ a;
   endfunction
   function automatic logic [7:0] mul_9(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ a;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      logic [7:0] a0, a1, a2, a3;
      block_type  o;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);   a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2); a3 = get_byte(s, c*4+3);
         o[127 - 32*c -: 8]      = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
         o[127 - 32*c - 8 -: 8]  = mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3);
         o[127 - 32*c - 16 -: 8] = mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3);
         o[127 - 32*c - 24 -: 8] = mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3);
      end
      return o;
   endfunction

   // inverse shift rows and inverse substitution
   function automatic block_type inv_shift_sub(input block_type s);
      block_type o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8*(((c + r) % 4)*4 + r) -: 8] = inv_sbox(get_byte(s, c*4 + r));
         end
      end
      return o;
   endfunction

endpackage

### hw/rtl/aescbc_if.sv
// ----------------------------------------------------------------------------
// AES-128 CBC channel interfaces
// Request, response and CSR write channels, each with source and sink views.
// ----------------------------------------------------------------------------
interface aescbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        first_block;
   modport source (output valid, block_high, block_low, first_block, input ready);
   modport sink   (input valid, block_high, block_low, first_block, output ready);
endinterface

interface aescbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aescbc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/aescbc_ram.sv
// ----------------------------------------------------------------------------
// AES-128 CBC generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aescbc_ram #(
   parameter int unsigned Width = 64,
   parameter int unsigned Depth = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hw/rtl/aescbc_keygen.sv
// ----------------------------------------------------------------------------
// AES-128 CBC key expansion
// Walks the ten-round schedule into the RAM as high and low round-key words.
// ----------------------------------------------------------------------------
module aescbc_keygen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [127:0]           key,
   output logic                   busy,
   output aescbc_pkg::key_wr_type key_wr
);
   import aescbc_pkg::*;

   logic [127:0] rk_ff, rk_in;
   logic [4:0]   addr_ff, addr_in;
   logic [7:0]   rc_ff, rc_in;
   logic         busy_ff, busy_in;
   logic [127:0] nxt;
   logic [31:0]  tw;

   // next round key from the current one
   always_comb begin
      tw = {fwd_sbox(rk_ff[23:16]) ^ rc_ff, fwd_sbox(rk_ff[15:8]),
            fwd_sbox(rk_ff[7:0]), fwd_sbox(rk_ff[31:24])};
      nxt[127:96] = rk_ff[127:96] ^ tw;
      nxt[95:64]  = rk_ff[95:64] ^ nxt[127:96];
      nxt[63:32]  = rk_ff[63:32] ^ nxt[95:64];
      nxt[31:0]   = rk_ff[31:0] ^ nxt[63:32];
   end

   // advance: even address writes high word, odd writes low word and steps key
   always_comb begin
      rk_in = rk_ff; addr_in = addr_ff; rc_in = rc_ff; busy_in = busy_ff;
      if (start) begin
         rk_in = key; addr_in = '0; rc_in = 8'h01; busy_in = 1'b1;
      end else if (busy_ff) begin
         addr_in = addr_ff + 5'd1;
         if (addr_ff[0]) begin
            rk_in = nxt;
            rc_in = xtime(rc_ff);
         end
         if (addr_ff == 5'(KeyWordCount - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rk_ff   <= rk_in;
      addr_ff <= addr_in;
      rc_ff   <= rc_in;
   end

   assign busy           = busy_ff;
   assign key_wr.wr_en   = busy_ff;
   assign key_wr.wr_addr = addr_ff;
   assign key_wr.wr_data = addr_ff[0] ? rk_ff[63:0] : rk_ff[127:64];
endmodule

### hw/rtl/aescbc_core.sv
// ----------------------------------------------------------------------------
// AES-128 CBC round engine
// Iterates one round at a time, reading round-key words from the RAM.
// ----------------------------------------------------------------------------
module aescbc_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         decrypt,
   input  logic [127:0] din,
   input  logic [63:0]  rk_word,
   output logic [4:0]   rk_addr,
   output logic         done,
   output logic [127:0] dout
);
   import aescbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_APPLY = 3'b100
   } st_type;

   st_type       st_ff, st_in;
   logic [127:0] s_ff, s_in;
   logic [63:0]  khi_ff, khi_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         half_ff, half_in;
   logic [127:0] rk;
   logic [127:0] stepped;
   logic [3:0]   rnd_sel;
   logic [3:0]   key_idx;
   logic         done_in;

   // round key index: the apply cycle already issues the next round's high word
   assign rnd_sel = (st_ff == ST_APPLY && !half_ff && rnd_ff != 4'd10) ?
                    rnd_ff + 4'd1 : rnd_ff;
   assign key_idx = decrypt ? 4'd10 - rnd_sel : rnd_sel;
   assign rk_addr = {key_idx, half_ff};
   assign rk      = {khi_ff, rk_word};

   // round transform ahead of the key add
   always_comb begin
      if (rnd_ff == 4'd0) begin
         stepped = s_ff;
      end else if (!decrypt) begin
         stepped = enc_round(s_ff, rnd_ff == 4'd10);
      end else begin
         stepped = inv_shift_sub(s_ff);
      end
   end

   // sequence: fetch high word, then per round capture high word and apply
   always_comb begin
      st_in = st_ff; s_in = s_ff; khi_in = khi_ff; rnd_in = rnd_ff;
      half_in = half_ff; done_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               s_in = din; rnd_in = '0; half_in = 1'b0; st_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            half_in = 1'b1;
            st_in   = ST_APPLY;
         end
         ST_APPLY: begin
            if (half_ff) begin
               khi_in  = rk_word;
               half_in = 1'b0;
            end else begin
               if (decrypt && rnd_ff != 4'd0 && rnd_ff != 4'd10) begin
                  s_in = inv_mix(stepped ^ rk);
               end else begin
                  s_in = stepped ^ rk;
               end
               half_in = 1'b1;
               if (rnd_ff == 4'd10) begin
                  done_in = 1'b1;
                  st_in   = ST_IDLE;
               end else begin
                  rnd_in = rnd_ff + 4'd1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         done  <= 1'b0;
      end else begin
         st_ff <= st_in;
         done  <= done_in;
      end
      s_ff    <= s_in;
      khi_ff  <= khi_in;
      rnd_ff  <= rnd_in;
      half_ff <= half_in;
   end

   assign dout = s_ff;
endmodule

### hw/rtl/aes128_cbc_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 CBC block cipher
// One 128-bit block in, one out; key schedule and chain state in RAM.
// ----------------------------------------------------------------------------
// channel | dir | beat
// req     | in  | block_high, block_low, first_block
// rsp     | out | result_high, result_low
// csr     | in  | index, data (key, iv, decrypt_mode)
//
// A block passes from req beat to rsp valid through 2 chain reads, the core
// start, a key fetch, 11 rounds (high and low round-key word each), core done
// and the result register; first_block first writes the IV to chain RAM.
// A key write starts a walk over all 22 key words; req is held off meanwhile.
// Reset is synchronous; round keys are undefined until a key write.
// A held rsp beat stalls the input; the next req is taken after the rsp beat.
module aes128_cbc_block_cipher (
   input logic          clock,
   input logic          reset,
   aescbc_req_if.sink   req,
   aescbc_rsp_if.source rsp,
   aescbc_csr_if.sink   csr
);
   import aescbc_pkg::*;

   logic [63:0]  key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic         decrypt_ff;
   logic         busy_ff;
   logic         rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic [127:0] blk_ff;
   logic         kick_ff;
   logic         key_start;
   logic         kg_busy;
   key_wr_type   key_wr;
   logic [63:0]  rk_word;
   logic [4:0]   rk_addr;
   logic         core_done;
   logic [127:0] core_out;
   logic         req_beat, csr_beat;
   // chain state words in a two-entry RAM
   logic         cv_we;
   logic         cv_waddr;
   logic [63:0]  cv_wdata;
   logic         cv_raddr;
   logic [63:0]  cv_rdata;
   logic [63:0]  cv_hi_ff;
   logic         cv_ph_ff;
   logic         cv_ok_ff;
   logic         core_start;
   logic [127:0] cv_full;
   logic [127:0] core_in;
   logic [127:0] res;
   logic [1:0]   wpend_ff;
   logic [127:0] wval_ff;
   logic         core_running;
   logic         core_running_ff;

   assign csr_beat  = csr.valid && csr.ready;
   assign req_beat  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign req.ready = !busy_ff && !kg_busy && !key_start && !rsp_valid_ff;
   assign key_start = csr_beat &&
      (csr.index == CSR_KEY_HIGH || csr.index == CSR_KEY_LOW);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0; key_low_ff <= '0; iv_high_ff <= '0; iv_low_ff <= '0;
         decrypt_ff  <= 1'b0;
      end else if (csr_beat) begin
         case (csr.index)
            CSR_KEY_HIGH:     key_high_ff <= csr.data;
            CSR_KEY_LOW:      key_low_ff  <= csr.data;
            CSR_IV_HIGH:      iv_high_ff  <= csr.data;
            CSR_IV_LOW:       iv_low_ff   <= csr.data;
            CSR_DECRYPT_MODE: decrypt_ff  <= csr.data[0];
            default: ;
         endcase
      end
   end

   aescbc_keygen u_keygen (
      .clock  (clock),
      .reset  (reset),
      .start  (key_start),
      .key    (csr.index == CSR_KEY_HIGH ? {csr.data, key_low_ff}
                                         : {key_high_ff, csr.data}),
      .busy   (kg_busy),
      .key_wr (key_wr)
   );

   aescbc_ram #(.Width(64), .Depth(KeyWordCount)) u_rk_ram (
      .clock   (clock),
      .wr_en   (key_wr.wr_en),
      .wr_addr (key_wr.wr_addr),
      .wr_data (key_wr.wr_data),
      .rd_addr (rk_addr),
      .rd_data (rk_word)
   );

   // chain read: word 0 then word 1, each landing in the cycle after its issue
   assign cv_raddr = cv_ph_ff;
   aescbc_ram #(.Width(64), .Depth(2)) u_cv_ram (
      .clock   (clock),
      .wr_en   (cv_we),
      .wr_addr (cv_waddr),
      .wr_data (cv_wdata),
      .rd_addr (cv_raddr),
      .rd_data (cv_rdata)
   );

   assign cv_full = {cv_hi_ff, cv_rdata};
   assign core_in = decrypt_ff ? blk_ff : (blk_ff ^ cv_full);
   assign res     = decrypt_ff ? (core_out ^ cv_full) : core_out;

   // write-back pending: 2 = high word, 1 = low word; reset seeds zeros
   always_comb begin
      cv_we    = 1'b0;
      cv_waddr = 1'b0;
      cv_wdata = '0;
      if (wpend_ff == 2'd2) begin
         cv_we = 1'b1; cv_waddr = 1'b0; cv_wdata = wval_ff[127:64];
      end else if (wpend_ff == 2'd1) begin
         cv_we = 1'b1; cv_waddr = 1'b1; cv_wdata = wval_ff[63:0];
      end
   end

   // block sequencing: load chain, run core, write chain back
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         kick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cv_ph_ff     <= 1'b0;
         cv_ok_ff     <= 1'b0;
         wpend_ff     <= 2'd2;
         wval_ff      <= '0;
      end else begin
         kick_ff <= req_beat;
         // chain write-back: ciphertext or IV reload, else count down
         if (core_done) begin
            wval_ff  <= decrypt_ff ? blk_ff : core_out;
            wpend_ff <= 2'd2;
         end else if (req_beat && req.first_block) begin
            wval_ff  <= {iv_high_ff, iv_low_ff};
            wpend_ff <= 2'd2;
         end else if (wpend_ff != 2'd0) begin
            wpend_ff <= wpend_ff - 2'd1;
         end
         if (req_beat) begin
            busy_ff  <= 1'b1;
            blk_ff   <= {req.block_high, req.block_low};
            cv_ph_ff <= 1'b0;
            cv_ok_ff <= 1'b0;
         end else if (core_done) begin
            busy_ff <= 1'b0;
         end else if (busy_ff && !cv_ok_ff && wpend_ff == 2'd0) begin
            // stage chain read: phase 0 issues high, phase 1 issues low
            if (!cv_ph_ff) begin
               cv_ph_ff <= 1'b1;
            end else begin
               cv_ok_ff <= 1'b1;
            end
         end
         if (core_done) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture high chain word in the cycle after its read is issued
   always_ff @(posedge clock) begin
      if (busy_ff && !cv_ok_ff && cv_ph_ff) begin
         cv_hi_ff <= cv_rdata;
      end
   end

   // start core once low chain word sits on the RAM output
   assign core_start = busy_ff && cv_ok_ff && !kick_ff &&
                       cv_raddr && !core_running;

   assign core_running = core_running_ff;
   always_ff @(posedge clock) begin
      if (reset || req_beat) begin
         core_running_ff <= 1'b0;
      end else if (core_start) begin
         core_running_ff <= 1'b1;
      end
   end

   aescbc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (core_start),
      .decrypt (decrypt_ff),
      .din     (core_in),
      .rk_word (rk_word),
      .rk_addr (rk_addr),
      .done    (core_done),
      .dout    (core_out)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_high = rsp_data_ff[127:64];
   assign rsp.result_low  = rsp_data_ff[63:0];

   // a result appears only after a block was taken
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      core_done |-> busy_ff) else $error("core finished while idle");
   // no input is taken while a result waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("accept with result pending");
   // key schedule never overlaps block work
   a_key_vs_block: assert property (@(posedge clock) disable iff (reset)
      kg_busy |-> !busy_ff) else $error("key walk during block");
endmodule
